// File: hdl/rpa_pkg.sv
// Shared types, codes and constants for the reference-counted page allocator.
// No dependencies; every other file in hdl/ but rpa_ram refers to this package by scoped names.
`default_nettype none

package rpa_pkg;

   // Fixed field widths
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned COUNT_OUT_W = 16;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;

   // Default sizing of the block
   localparam int unsigned DEF_NUM_PAGES  = 32768;
   localparam int unsigned DEF_PAGE_BYTES = 4096;
   localparam int unsigned DEF_COUNT_BITS = 16;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOCATE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SHARE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SEED     = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNREF    = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LIMIT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_LIMIT = 1'd1;

   // Register reset values
   localparam logic [ADDR_W-1:0] LOW_LIMIT_RESET  = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] HIGH_LIMIT_RESET = 32'h8800_0000;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // take the request word, issue memory reads
      logic exec;   // commit memory writes, load the response register
   } rpa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_free;   // response register can take a word this cycle
   } rpa_stat_type;

endpackage

`default_nettype wire

// File: hdl/rpa_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on rpa_pkg for field widths.
`default_nettype none

interface rpa_req_if;
   logic                             valid;
   logic                             ready;
   logic [rpa_pkg::KIND_W-1:0]       kind;
   logic [rpa_pkg::ADDR_W-1:0]       page_address;

   modport source (output valid, output kind, output page_address, input ready);
   modport sink   (input valid, input kind, input page_address, output ready);
endinterface

interface rpa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rpa_pkg::STATUS_W-1:0]     status;
   logic [rpa_pkg::ADDR_W-1:0]       result_address;
   logic                             page_freed;
   logic [rpa_pkg::COUNT_OUT_W-1:0]  new_count;

   modport source (output valid, output status, output result_address,
                   output page_freed, output new_count, input ready);
   modport sink   (input valid, input status, input result_address,
                   input page_freed, input new_count, output ready);
endinterface

`default_nettype wire

// File: hdl/rpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module rpa_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                                            clock,
   input  wire logic                                            wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0]                                wr_data,
   input  wire logic                                            rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic      [WIDTH-1:0]                                rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/rpa_controller.sv
// Two-state sequencer: accept a request word, then commit it once the response slot is free.
// Depends on rpa_pkg for the command and status structs.
`default_nettype none

module rpa_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire rpa_pkg::rpa_stat_type stat,
   output rpa_pkg::rpa_cmd_type       cmd
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // read data is ready; wait only for the response register
            if (stat.slot_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/rpa_datapath.sv
// Allocator datapath: limit registers, address decode, free stack and count RAMs,
// stack pointer and the response register. Depends on rpa_pkg and rpa_ram.
`default_nettype none

module rpa_datapath #(
   parameter int unsigned NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
   parameter int unsigned PAGE_BYTES = rpa_pkg::DEF_PAGE_BYTES,
   parameter int unsigned COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rpa_pkg::rpa_cmd_type                cmd,
   output rpa_pkg::rpa_stat_type                    stat,
   input  wire logic                                csr_write_enable,
   input  wire logic [rpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rpa_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  wire logic [rpa_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [rpa_pkg::ADDR_W-1:0]          req_page_address,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic [rpa_pkg::STATUS_W-1:0]             rsp_status,
   output logic [rpa_pkg::ADDR_W-1:0]               rsp_result_address,
   output logic                                     rsp_page_freed,
   output logic [rpa_pkg::COUNT_OUT_W-1:0]          rsp_new_count
);
   localparam int unsigned AW    = rpa_pkg::ADDR_W;
   localparam int unsigned IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int unsigned TOP_W = $clog2(NUM_PAGES + 1);
   localparam int unsigned OFF_W = $clog2(PAGE_BYTES);
   localparam int unsigned PN_W  = AW - OFF_W;
   localparam logic [AW:0]    OFF_MASK  = (AW + 1)'(PAGE_BYTES - 1);
   localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(NUM_PAGES);

   // ---------------- limit registers ----------------
   logic [AW-1:0] low_limit_ff,  low_limit_in;
   logic [AW-1:0] high_limit_ff, high_limit_in;
   logic [AW:0]   base_addr_ff,  base_addr_in;   // low_limit rounded up to a page

   always_comb begin
      low_limit_in  = low_limit_ff;
      high_limit_in = high_limit_ff;
      base_addr_in  = base_addr_ff;
      if (csr_write_enable) begin
         if (csr_index == rpa_pkg::CSR_LOW_LIMIT) begin
            low_limit_in = csr_write_data;
            base_addr_in = ({1'b0, csr_write_data} + OFF_MASK) & ~OFF_MASK;
         end else if (csr_index == rpa_pkg::CSR_HIGH_LIMIT) begin
            high_limit_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= rpa_pkg::LOW_LIMIT_RESET;
         high_limit_ff <= rpa_pkg::HIGH_LIMIT_RESET;
         base_addr_ff  <= ({1'b0, rpa_pkg::LOW_LIMIT_RESET} + OFF_MASK) & ~OFF_MASK;
      end else begin
         low_limit_ff  <= low_limit_in;
         high_limit_ff <= high_limit_in;
         base_addr_ff  <= base_addr_in;
      end
   end

   // ---------------- address decode ----------------
   logic [PN_W:0]    page_num;
   logic             addr_ok;
   logic [IDX_W-1:0] dec_idx;

   always_comb begin
      page_num = {1'b0, req_page_address[AW-1:OFF_W]} - base_addr_ff[AW:OFF_W];
      addr_ok  = (req_page_address[OFF_W-1:0] == '0)
              && (req_page_address >= low_limit_ff)
              && (req_page_address < high_limit_ff)
              && ((AW + 1)'(page_num) < (AW + 1)'(NUM_PAGES));
      dec_idx  = IDX_W'(page_num);
   end

   // ---------------- request registers ----------------
   logic [rpa_pkg::KIND_W-1:0] kind_ff;
   logic [AW-1:0]              addr_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic                       addr_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         addr_ff    <= req_page_address;
         idx_ff     <= dec_idx;
         addr_ok_ff <= addr_ok;
      end
   end

   // ---------------- memories ----------------
   logic [TOP_W-1:0]      stack_top_ff, stack_top_in;
   logic [IDX_W-1:0]      stack_rd;
   logic                  stack_we;
   logic [COUNT_BITS-1:0] count_rd;
   logic                  count_we;
   logic [IDX_W-1:0]      count_wa;
   logic [COUNT_BITS-1:0] count_wd;

   rpa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_PAGES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (IDX_W'(stack_top_ff)),
      .wr_data (idx_ff),
      .rd_en   (cmd.load),
      .rd_addr (IDX_W'(stack_top_ff - 1'b1)),
      .rd_data (stack_rd)
   );

   rpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (count_wa),
      .wr_data (count_wd),
      .rd_en   (cmd.load),
      .rd_addr (dec_idx),
      .rd_data (count_rd)
   );

   // ---------------- execute ----------------
   logic [rpa_pkg::STATUS_W-1:0] res_status;
   logic [AW-1:0]                res_addr;
   logic                         res_freed;
   logic [COUNT_BITS-1:0]        res_count;
   logic                         want_push;
   logic                         do_pop;
   logic                         do_push;
   logic                         set_count;

   always_comb begin
      res_status = rpa_pkg::STATUS_OK;
      res_addr   = addr_ff;
      res_count  = '0;
      count_wa   = idx_ff;
      count_wd   = '0;
      set_count  = 1'b0;
      want_push  = 1'b0;
      do_pop     = 1'b0;
      if (kind_ff == rpa_pkg::KIND_ALLOCATE) begin
         if (stack_top_ff == '0) begin
            res_status = rpa_pkg::STATUS_NO_FREE;
            res_addr   = '0;
         end else begin
            do_pop    = 1'b1;
            set_count = 1'b1;
            count_wa  = stack_rd;
            count_wd  = COUNT_BITS'(1);
            res_count = COUNT_BITS'(1);
            res_addr  = base_addr_ff[AW-1:0] + AW'(64'(stack_rd) << OFF_W);
         end
      end else if (!addr_ok_ff) begin
         res_status = rpa_pkg::STATUS_BAD_ADDR;
      end else begin
         case (kind_ff)
            rpa_pkg::KIND_RELEASE: begin
               if (count_rd == '0) begin
                  res_status = rpa_pkg::STATUS_UNREF;
               end else begin
                  set_count = 1'b1;
                  count_wd  = count_rd - 1'b1;
                  res_count = count_rd - 1'b1;
                  want_push = (count_rd == COUNT_BITS'(1));
               end
            end
            rpa_pkg::KIND_SHARE: begin
               // saturating increment
               set_count = 1'b1;
               count_wd  = (count_rd == '1) ? count_rd : count_rd + 1'b1;
               res_count = count_wd;
            end
            rpa_pkg::KIND_SEED: begin
               set_count = 1'b1;
               want_push = 1'b1;
            end
            default: begin
               res_status = rpa_pkg::STATUS_OK;
            end
         endcase
      end
      // a push onto a full stack is dropped
      do_push   = want_push && (stack_top_ff != TOP_FULL);
      res_freed = do_push;
      count_we  = cmd.exec && set_count;
      stack_we  = cmd.exec && do_push;
   end

   always_comb begin
      stack_top_in = stack_top_ff;
      if (cmd.exec && do_pop) begin
         stack_top_in = stack_top_ff - 1'b1;
      end else if (cmd.exec && do_push) begin
         stack_top_in = stack_top_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_top_ff <= '0;
      end else begin
         stack_top_ff <= stack_top_in;
      end
   end

   // ---------------- response register ----------------
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [AW-1:0]                rsp_addr_ff;
   logic                         rsp_freed_ff;
   logic [rpa_pkg::COUNT_OUT_W-1:0] rsp_count_ff;

   assign rsp_valid_in = cmd.exec || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff <= res_status;
         rsp_addr_ff   <= res_addr;
         rsp_freed_ff  <= res_freed;
         rsp_count_ff  <= rpa_pkg::COUNT_OUT_W'(res_count);
      end
   end

   assign stat.slot_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_page_freed     = rsp_freed_ff;
   assign rsp_new_count      = rsp_count_ff;

endmodule

`default_nettype wire

// File: hdl/refcounted_page_allocator.sv
// A request word is registered at accept and committed in the execute state once the response
// slot is free, and the response register loads at that commit. No request is taken until the
// last one commits (count and free-stack RAMs: read issued at accept, write at commit).
// A waiting response word does not block the next request; only a response still unread
// when the next one is ready holds the block. Reset empties the free stack and restores the
// limits; the RAMs are not cleared (no clearing pass), pages enter only through seed requests.
`default_nettype none

module refcounted_page_allocator #(
   parameter int unsigned NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
   parameter int unsigned PAGE_BYTES = rpa_pkg::DEF_PAGE_BYTES,
   parameter int unsigned COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rpa_req_if.sink                               req_bus,
   rpa_rsp_if.source                             rsp_bus,
   input  wire logic                             csr_write_enable,
   input  wire logic [rpa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rpa_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   rpa_pkg::rpa_cmd_type  cmd;
   rpa_pkg::rpa_stat_type stat;
   logic                  req_ready;

   rpa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rpa_datapath #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_kind           (req_bus.kind),
      .req_page_address   (req_bus.page_address),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_status         (rsp_bus.status),
      .rsp_result_address (rsp_bus.result_address),
      .rsp_page_freed     (rsp_bus.page_freed),
      .rsp_new_count      (rsp_bus.new_count)
   );

   assign req_bus.ready = req_ready;

   // ---------------- assertions ----------------
   // an accepted request is committed before the next one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while previous one in flight");

   // a new response word only follows a cycle spent committing a request
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(!req_bus.ready))
      else $error("response appeared without a committed request");

   // failed operations touch no page
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != rpa_pkg::STATUS_OK))
         |-> (rsp_bus.new_count == '0) && !rsp_bus.page_freed)
      else $error("error response reports a count or a freed page");

   // an empty allocate reports a null address
   a_empty_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == rpa_pkg::STATUS_NO_FREE))
         |-> (rsp_bus.result_address == '0))
      else $error("empty allocate returned a nonzero address");

endmodule

`default_nettype wire
